// File: rtl/efr_pkg.sv
// ----------------------------------------------------------------------------
// efr_pkg
// Shared types and constants for the escaped frame receiver: byte codes,
// frame position codes, result kinds and the result item.
// ----------------------------------------------------------------------------
`default_nettype none

package efr_pkg;

	localparam int unsigned POS_W = 17;

	localparam logic [7:0] DELIM_BYTE = 8'h7E;
	localparam logic [7:0] ESC_BYTE   = 8'h7D;
	localparam logic [7:0] ESC_XOR    = 8'h20;
	localparam logic [7:0] SUM_BASE   = 8'hFF;
	localparam logic [15:0] HDR_BYTES = 16'd3;

	// Frame position codes; the payload and the check byte start at POS_PAYLOAD.
	localparam logic [POS_W-1:0] POS_IDLE    = 17'd0;
	localparam logic [POS_W-1:0] POS_LEN_HI  = 17'd1;
	localparam logic [POS_W-1:0] POS_LEN_LO  = 17'd2;
	localparam logic [POS_W-1:0] POS_ADDR    = 17'd3;
	localparam logic [POS_W-1:0] POS_TYPE    = 17'd4;
	localparam logic [POS_W-1:0] POS_PAYLOAD = 17'd5;
	localparam logic [POS_W-1:0] POS_LEN_OFS = 17'd2;

	typedef enum logic [2:0] {
		KIND_DATA    = 3'd0,
		KIND_OK      = 3'd1,
		KIND_BAD_SUM = 3'd2,
		KIND_ABORT   = 3'd3,
		KIND_BAD_LEN = 3'd4
	} efr_kind_t;

	typedef struct packed {
		efr_kind_t   kind;
		logic [7:0]  data_byte;
		logic [15:0] byte_index;
		logic [7:0]  dest_addr;
		logic [7:0]  payload_type;
		logic [15:0] payload_length;
	} efr_result_t;

endpackage

`default_nettype wire

// File: rtl/efr_rx_if.sv
// ----------------------------------------------------------------------------
// efr_rx_if
// Valid/ready channel that carries one raw received byte per item.
// ----------------------------------------------------------------------------
`default_nettype none

interface efr_rx_if;
	logic       valid;
	logic       ready;
	logic [7:0] rx_byte;

	modport source (output valid, output rx_byte, input ready);
	modport sink   (input valid, input rx_byte, output ready);
endinterface

`default_nettype wire

// File: rtl/efr_evt_if.sv
// ----------------------------------------------------------------------------
// efr_evt_if
// Valid/ready channel that carries one receiver result item.
// ----------------------------------------------------------------------------
`default_nettype none

interface efr_evt_if
	import efr_pkg::*;
;
	logic        valid;
	logic        ready;
	efr_result_t result;

	modport source (output valid, output result, input ready);
	modport sink   (input valid, input result, output ready);
endinterface

`default_nettype wire

// File: rtl/escaped_frame_receiver.sv
// ----------------------------------------------------------------------------
// escaped_frame_receiver
// Byte-wise parser for escaped, delimited frames with an 8-bit checksum.
// ----------------------------------------------------------------------------
// Usage: raw serial bytes enter on the rx channel, one byte per item. Each
// byte gives at most one item on the evt channel: a payload byte with its
// index, a frame ok or checksum bad report at the check byte, an abort when
// a delimiter arrives mid-frame, or a bad length report.
// A byte is captured in an input register, decoded against the frame state
// and written to the result register, from which evt takes the item.
// One byte is accepted every cycle while evt takes its items; the decoder
// updates its whole state as it decodes each byte, which sets that rate.
// When evt stalls, the result register holds its item; one more byte may
// wait in the input register, after which rx ready drops until the result
// is taken. A byte waits there while a result is held even when it gives
// no result itself.
// Reset returns the parser to idle with no escape pending, a zero sum and
// empty input and result registers.
// ----------------------------------------------------------------------------
`default_nettype none

module escaped_frame_receiver
	import efr_pkg::*;
(
	input  wire logic  clk,
	input  wire logic  arst_n,
	efr_rx_if.sink     rx,
	efr_evt_if.source  evt
);

	logic              valid_s1;
	logic [7:0]        byte_s1;
	logic              advance;

	logic              esc_q,   esc_n;
	logic [POS_W-1:0]  pos_q,   pos_n;
	logic [15:0]       len_q,   len_n;
	logic [7:0]        addr_q,  addr_n;
	logic [7:0]        type_q,  type_n;
	logic [7:0]        sum_q,   sum_n;

	logic              res_valid_q;
	efr_result_t       res_q;
	efr_result_t       res_d;
	logic              emit;

	logic [7:0]        b;
	logic              is_data;
	logic [15:0]       len_lo;
	logic [POS_W-1:0]  end_pos;
	logic [POS_W-1:0]  idx_full;
	logic [15:0]       len_field;

	assign advance  = valid_s1 && (!res_valid_q || evt.ready);
	assign rx.ready = !valid_s1 || advance;

	assign end_pos   = {1'b0, len_q} + POS_LEN_OFS;
	assign idx_full  = pos_q - POS_PAYLOAD;
	assign len_field = len_q - HDR_BYTES;

	always_comb begin
		esc_n   = esc_q;
		pos_n   = pos_q;
		len_n   = len_q;
		addr_n  = addr_q;
		type_n  = type_q;
		sum_n   = sum_q;
		emit    = 1'b0;
		is_data = 1'b0;
		b       = byte_s1;
		len_lo  = '0;

		res_d.kind           = KIND_DATA;
		res_d.data_byte      = '0;
		res_d.byte_index     = '0;
		res_d.dest_addr      = addr_q;
		res_d.payload_type   = type_q;
		res_d.payload_length = '0;

		if (byte_s1 == DELIM_BYTE) begin
			if (pos_q != POS_IDLE) begin
				emit       = 1'b1;
				res_d.kind = KIND_ABORT;
				if (pos_q > POS_LEN_LO && len_q >= HDR_BYTES) begin
					res_d.payload_length = len_field;
				end
			end
			esc_n  = 1'b0;
			pos_n  = POS_LEN_HI;
			sum_n  = '0;
			addr_n = '0;
			type_n = '0;
		end else if (esc_q) begin
			esc_n   = 1'b0;
			b       = byte_s1 ^ ESC_XOR;
			is_data = 1'b1;
		end else if (byte_s1 == ESC_BYTE) begin
			esc_n = 1'b1;
		end else begin
			is_data = 1'b1;
		end

		if (is_data) begin
			case (pos_q)
				POS_IDLE: begin
				end
				POS_LEN_HI: begin
					len_n = {b, 8'h00};
					pos_n = POS_LEN_LO;
				end
				POS_LEN_LO: begin
					len_lo = {len_q[15:8], b};
					len_n  = len_lo;
					if (len_lo < HDR_BYTES) begin
						emit       = 1'b1;
						res_d.kind = KIND_BAD_LEN;
						pos_n      = POS_IDLE;
						sum_n      = '0;
					end else begin
						pos_n = POS_ADDR;
					end
				end
				POS_ADDR: begin
					addr_n = b;
					sum_n  = b;
					pos_n  = POS_TYPE;
				end
				POS_TYPE: begin
					type_n = b;
					sum_n  = sum_q + b;
					pos_n  = POS_PAYLOAD;
				end
				default: begin
					emit                 = 1'b1;
					res_d.payload_length = len_field;
					if (pos_q >= end_pos) begin
						// Check byte: the frame is good when it completes the sum to 0xFF.
						res_d.kind = ((SUM_BASE - sum_q) == b) ? KIND_OK : KIND_BAD_SUM;
						pos_n      = POS_IDLE;
						sum_n      = '0;
					end else begin
						res_d.kind       = KIND_DATA;
						res_d.data_byte  = b;
						res_d.byte_index = idx_full[15:0];
						sum_n            = sum_q + b;
						pos_n            = pos_q + 17'd1;
					end
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (rx.ready) begin
			valid_s1 <= rx.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (rx.ready && rx.valid) begin
			byte_s1 <= rx.rx_byte;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			esc_q  <= 1'b0;
			pos_q  <= POS_IDLE;
			len_q  <= '0;
			addr_q <= '0;
			type_q <= '0;
			sum_q  <= '0;
		end else if (advance) begin
			esc_q  <= esc_n;
			pos_q  <= pos_n;
			len_q  <= len_n;
			addr_q <= addr_n;
			type_q <= type_n;
			sum_q  <= sum_n;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (advance) begin
			res_valid_q <= emit;
		end else if (evt.ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && emit) begin
			res_q <= res_d;
		end
	end

	assign evt.valid  = res_valid_q;
	assign evt.result = res_q;

endmodule

`default_nettype wire
